// ----- hdl/nsbh_pkg.sv -----
// Shared widths, constants and control types for the nearest swept box hit block.
`default_nettype none
package nsbh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ID_BITS   = 16;
    localparam int COORD_W   = 32;
    localparam int SIZE_W    = 31;
    localparam int NUM_W     = COORD_W + 2;        // bound minus origin, signed
    localparam int DEN_W     = COORD_W + 1;        // movement, signed
    localparam int MAG_W     = COORD_W + 1;        // magnitude of a numerator or movement
    localparam int QW        = FRAC_BITS + 3;      // unsigned quotient, up to 4.0
    localparam int QS_W      = FRAC_BITS + 4;      // signed quotient, +-4.0
    localparam int FRAC_W    = FRAC_BITS + 1;      // fraction 0..1.0
    localparam int PROD_W    = DEN_W + FRAC_W + 1; // movement times fraction
    localparam int CNT_W     = $clog2(QW + 1);

    localparam logic [QW-1:0]   QUOT_LIMIT = QW'(4 << FRAC_BITS);
    localparam logic [QS_W-1:0] ONE_FRAC   = QS_W'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        SEL_XLO,
        SEL_XHI,
        SEL_YLO,
        SEL_YHI
    } slab_sel_t;

    typedef struct packed {
        logic      latch;
        logic      div_start;
        slab_sel_t sel;
        logic      fold;
        logic      update;
        logic      scale;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic blocks;
        logic last;
        logic dx_zero;
        logic dy_zero;
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/nsbh_div.sv -----
// Iterative restoring divider: saturated Q.FRAC_BITS quotient of two magnitudes.
`default_nettype none
module nsbh_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [nsbh_pkg::MAG_W-1:0]  num_mag,
    input  wire logic [nsbh_pkg::MAG_W-1:0]  den_mag,
    output logic                             done,
    output logic      [nsbh_pkg::QW-1:0]     quot
);

    logic [nsbh_pkg::MAG_W-1:0] rem_reg, rem_next;
    logic [nsbh_pkg::MAG_W-1:0] den_reg, den_next;
    logic [nsbh_pkg::QW-1:0]    sh_reg, sh_next;
    logic [nsbh_pkg::QW-1:0]    q_reg, q_next;
    logic [nsbh_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [nsbh_pkg::MAG_W:0]   trial;
    logic                       too_big;

    assign too_big = {3'b000, num_mag} >= {den_mag, 3'b000};
    assign trial   = {rem_reg, sh_reg[nsbh_pkg::QW-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next = den_mag;
            if (too_big)
            begin
                // quotient is at least 8.0: saturate without iterating
                q_next    = nsbh_pkg::QUOT_LIMIT;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {3'b000, num_mag[nsbh_pkg::MAG_W-1:3]};
                sh_next   = {num_mag[2:0], {nsbh_pkg::FRAC_BITS{1'b0}}};
                cnt_next  = nsbh_pkg::CNT_W'(nsbh_pkg::QW);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = nsbh_pkg::MAG_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[nsbh_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[nsbh_pkg::MAG_W-1:0];
                q_next   = {q_reg[nsbh_pkg::QW-2:0], 1'b0};
            end
            sh_next  = {sh_reg[nsbh_pkg::QW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == nsbh_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = (q_reg > nsbh_pkg::QUOT_LIMIT) ? nsbh_pkg::QUOT_LIMIT : q_reg;

endmodule
`default_nettype wire

// ----- hdl/nsbh_dp.sv -----
// Datapath: request registers, slab clipping, nearest-hit tracking and hit point.
`default_nettype none
module nsbh_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire nsbh_pkg::dp_cmd_t                    cmd,
    output nsbh_pkg::dp_status_t                      status,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  start_y,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  end_x,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  end_y,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  box_x,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  box_y,
    input  wire logic        [nsbh_pkg::SIZE_W-1:0]   box_w,
    input  wire logic        [nsbh_pkg::SIZE_W-1:0]   box_h,
    input  wire logic                                 blocks,
    input  wire logic        [nsbh_pkg::ID_BITS-1:0]  object_id,
    input  wire logic                                 last_object,
    output logic                                      hit_found,
    output logic             [nsbh_pkg::ID_BITS-1:0]  hit_id,
    output logic             [nsbh_pkg::FRAC_W-1:0]   hit_fraction,
    output logic signed      [nsbh_pkg::COORD_W-1:0]  hit_x,
    output logic signed      [nsbh_pkg::COORD_W-1:0]  hit_y
);

    localparam int CW = nsbh_pkg::COORD_W;
    localparam int F  = nsbh_pkg::FRAC_BITS;

    logic signed [CW-1:0]                 sx_reg, sy_reg, ex_reg, ey_reg, bx_reg, by_reg;
    logic        [nsbh_pkg::SIZE_W-1:0]   bw_reg, bh_reg;
    logic                                 blocks_reg, last_reg;
    logic        [nsbh_pkg::ID_BITS-1:0]  id_reg;

    logic signed [nsbh_pkg::QS_W-1:0]     entry_reg, exit_reg, a_reg;
    logic                                 best_valid_reg;
    logic        [nsbh_pkg::FRAC_W-1:0]   best_frac_reg;
    logic        [nsbh_pkg::ID_BITS-1:0]  best_id_reg;
    logic signed [nsbh_pkg::PROD_W-1:0]   prod_x_reg, prod_y_reg;

    logic signed [nsbh_pkg::DEN_W-1:0]    dx, dy, den;
    logic signed [nsbh_pkg::NUM_W-1:0]    lo_x, hi_x, lo_y, hi_y, num;
    logic signed [nsbh_pkg::NUM_W-1:0]    num_neg;
    logic signed [nsbh_pkg::DEN_W-1:0]    den_neg;
    logic        [nsbh_pkg::MAG_W-1:0]    num_mag, den_mag;
    logic        [nsbh_pkg::QW-1:0]       quot;
    logic                                 div_done, q_neg;
    logic signed [nsbh_pkg::QS_W-1:0]     qs, q_min, q_max;
    logic                                 ok_x, ok_y, hit;
    logic        [nsbh_pkg::FRAC_W-1:0]   frac;
    logic                                 better;

    assign dx   = nsbh_pkg::DEN_W'(ex_reg) - nsbh_pkg::DEN_W'(sx_reg);
    assign dy   = nsbh_pkg::DEN_W'(ey_reg) - nsbh_pkg::DEN_W'(sy_reg);
    assign lo_x = nsbh_pkg::NUM_W'(bx_reg) - nsbh_pkg::NUM_W'(sx_reg);
    assign lo_y = nsbh_pkg::NUM_W'(by_reg) - nsbh_pkg::NUM_W'(sy_reg);
    assign hi_x = lo_x + $signed({3'b000, bw_reg});
    assign hi_y = lo_y + $signed({3'b000, bh_reg});

    always_comb
    begin
        unique case (cmd.sel)
            nsbh_pkg::SEL_XLO: num = lo_x;
            nsbh_pkg::SEL_XHI: num = hi_x;
            nsbh_pkg::SEL_YLO: num = lo_y;
            nsbh_pkg::SEL_YHI: num = hi_y;
            default:           num = lo_x;
        endcase
    end

    assign den     = (cmd.sel == nsbh_pkg::SEL_XLO || cmd.sel == nsbh_pkg::SEL_XHI) ? dx : dy;
    assign num_neg = -num;
    assign den_neg = -den;
    assign num_mag = num[nsbh_pkg::NUM_W-1] ? num_neg[nsbh_pkg::MAG_W-1:0]
                                            : num[nsbh_pkg::MAG_W-1:0];
    assign den_mag = den[nsbh_pkg::DEN_W-1] ? den_neg : den;
    assign q_neg   = num[nsbh_pkg::NUM_W-1] ^ den[nsbh_pkg::DEN_W-1];

    nsbh_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num_mag (num_mag),
        .den_mag (den_mag),
        .done    (div_done),
        .quot    (quot)
    );

    assign qs    = q_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign q_min = (a_reg < qs) ? a_reg : qs;
    assign q_max = (a_reg < qs) ? qs : a_reg;

    // a still axis passes only if its start lies inside the slab
    assign ok_x = (dx != '0) || (nsbh_pkg::NUM_W'(sx_reg) >= nsbh_pkg::NUM_W'(bx_reg)
                                 && hi_x >= 0);
    assign ok_y = (dy != '0) || (nsbh_pkg::NUM_W'(sy_reg) >= nsbh_pkg::NUM_W'(by_reg)
                                 && hi_y >= 0);
    assign hit  = ok_x && ok_y && (entry_reg <= exit_reg) && (exit_reg >= 0)
                  && (entry_reg <= $signed(nsbh_pkg::ONE_FRAC));
    assign frac = (entry_reg < 0) ? '0 : entry_reg[nsbh_pkg::FRAC_W-1:0];
    assign better = !best_valid_reg || (frac < best_frac_reg)
                    || (frac == best_frac_reg && id_reg < best_id_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sx_reg     <= start_x;
            sy_reg     <= start_y;
            ex_reg     <= end_x;
            ey_reg     <= end_y;
            bx_reg     <= box_x;
            by_reg     <= box_y;
            bw_reg     <= box_w;
            bh_reg     <= box_h;
            blocks_reg <= blocks;
            id_reg     <= object_id;
            last_reg   <= last_object;
            entry_reg  <= '0;
            exit_reg   <= $signed(nsbh_pkg::ONE_FRAC);
        end
        else if (cmd.fold)
        begin
            if (cmd.sel == nsbh_pkg::SEL_XLO || cmd.sel == nsbh_pkg::SEL_YLO)
            begin
                a_reg <= qs;
            end
            else
            begin
                if (q_min > entry_reg)
                begin
                    entry_reg <= q_min;
                end
                if (q_max < exit_reg)
                begin
                    exit_reg <= q_max;
                end
            end
        end
        if (cmd.scale)
        begin
            prod_x_reg <= dx * $signed({1'b0, best_frac_reg});
            prod_y_reg <= dy * $signed({1'b0, best_frac_reg});
        end
        if (cmd.load_out)
        begin
            hit_found    <= best_valid_reg;
            hit_id       <= best_valid_reg ? best_id_reg : '0;
            hit_fraction <= best_valid_reg ? best_frac_reg : '0;
            hit_x        <= best_valid_reg ? sx_reg + prod_x_reg[F+CW-1:F] : '0;
            hit_y        <= best_valid_reg ? sy_reg + prod_y_reg[F+CW-1:F] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_frac_reg  <= '0;
            best_id_reg    <= '0;
        end
        else if (cmd.load_out)
        begin
            best_valid_reg <= 1'b0;
            best_frac_reg  <= '0;
            best_id_reg    <= '0;
        end
        else if (cmd.update && blocks_reg && hit && better)
        begin
            best_valid_reg <= 1'b1;
            best_frac_reg  <= frac;
            best_id_reg    <= id_reg;
        end
    end

    assign status.blocks   = blocks_reg;
    assign status.last     = last_reg;
    assign status.dx_zero  = (dx == '0);
    assign status.dy_zero  = (dy == '0);
    assign status.div_done = div_done;

    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> !best_valid_reg)
        else $error("nearest hit not cleared after result");

endmodule
`default_nettype wire

// ----- hdl/nsbh_ctrl.sv -----
// Controller: sequences latch, slab divisions, hit update, hit point and result.
`default_nettype none
module nsbh_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire nsbh_pkg::dp_status_t  status,
    output nsbh_pkg::dp_cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_UPDATE,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    nsbh_pkg::slab_sel_t sel_reg, sel_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept, out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                priority if (!status.blocks)
                begin
                    state_next = status.last ? S_SCALE : S_IDLE;
                end
                else if (!status.dx_zero)
                begin
                    sel_next   = nsbh_pkg::SEL_XLO;
                    state_next = S_DIV_GO;
                end
                else if (!status.dy_zero)
                begin
                    sel_next   = nsbh_pkg::SEL_YLO;
                    state_next = S_DIV_GO;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    unique case (sel_reg)
                        nsbh_pkg::SEL_XLO:
                        begin
                            sel_next   = nsbh_pkg::SEL_XHI;
                            state_next = S_DIV_GO;
                        end
                        nsbh_pkg::SEL_XHI:
                        begin
                            sel_next   = nsbh_pkg::SEL_YLO;
                            state_next = status.dy_zero ? S_UPDATE : S_DIV_GO;
                        end
                        nsbh_pkg::SEL_YLO:
                        begin
                            sel_next   = nsbh_pkg::SEL_YHI;
                            state_next = S_DIV_GO;
                        end
                        default:
                        begin
                            state_next = S_UPDATE;
                        end
                    endcase
                end
            end
            S_UPDATE:
            begin
                state_next = status.last ? S_SCALE : S_IDLE;
            end
            S_SCALE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= nsbh_pkg::SEL_XLO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cmd.latch     = accept;
    assign cmd.div_start = (state_reg == S_DIV_GO);
    assign cmd.sel       = sel_reg;
    assign cmd.fold      = (state_reg == S_DIV_WAIT) && status.div_done;
    assign cmd.update    = (state_reg == S_UPDATE);
    assign cmd.scale     = (state_reg == S_SCALE);
    assign cmd.load_out  = (state_reg == S_EMIT) && out_free;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("second request taken while one is in progress");

    a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT && !status.div_done) |=> state_reg == S_DIV_WAIT)
        else $error("left division wait before divider finished");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && out_stall) |=>
            (state_reg == S_EMIT && out_valid_reg))
        else $error("result overwrote a stalled output");

endmodule
`default_nettype wire

// ----- hdl/nearest_swept_box_hit.sv -----
// Top level: nearest hit of a segment against a run of axis-aligned boxes.
// A non-blocking object is only planned; a blocking one is planned, then runs up to four
// slab divisions, each started and then awaited, before the hit update.
// One shared iterative divider, one quotient bit a cycle, sets the rate; one request at a time.
// The last object then adds the hit point and the output load before the result is offered,
// and waits while an earlier result is still stalled.
// Reset (rst_n, asynchronous, active low) clears the controller, the running
// nearest hit and the output valid; a result is held until taken.
`default_nettype none
module nearest_swept_box_hit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  start_y,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  end_x,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  end_y,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  box_x,
    input  wire logic signed [nsbh_pkg::COORD_W-1:0]  box_y,
    input  wire logic        [nsbh_pkg::SIZE_W-1:0]   box_w,
    input  wire logic        [nsbh_pkg::SIZE_W-1:0]   box_h,
    input  wire logic                                 blocks,
    input  wire logic        [nsbh_pkg::ID_BITS-1:0]  object_id,
    input  wire logic                                 last_object,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      hit_found,
    output logic             [nsbh_pkg::ID_BITS-1:0]  hit_id,
    output logic             [nsbh_pkg::FRAC_W-1:0]   hit_fraction,
    output logic signed      [nsbh_pkg::COORD_W-1:0]  hit_x,
    output logic signed      [nsbh_pkg::COORD_W-1:0]  hit_y
);

    nsbh_pkg::dp_cmd_t    cmd;
    nsbh_pkg::dp_status_t status;

    nsbh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nsbh_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .box_x        (box_x),
        .box_y        (box_y),
        .box_w        (box_w),
        .box_h        (box_h),
        .blocks       (blocks),
        .object_id    (object_id),
        .last_object  (last_object),
        .hit_found    (hit_found),
        .hit_id       (hit_id),
        .hit_fraction (hit_fraction),
        .hit_x        (hit_x),
        .hit_y        (hit_y)
    );

endmodule
`default_nettype wire

// ----- tb/nearest_swept_box_hit_test.sv -----
// Testbench for the nearest swept box hit block: random and directed object runs.
`default_nettype none
module nearest_swept_box_hit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = 64'sd1 << nsbh_pkg::FRAC_BITS;

    typedef struct {
        logic        found;
        logic [15:0] id;
        logic [16:0] frac;
        logic [31:0] px;
        logic [31:0] py;
    } hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic signed [31:0] box_x = '0, box_y = '0;
    logic [30:0] box_w = '0, box_h = '0;
    logic blocks = 1'b0, last_object = 1'b0;
    logic [15:0] object_id = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit_found;
    logic [15:0] hit_id;
    logic [16:0] hit_fraction;
    logic signed [31:0] hit_x, hit_y;

    nearest_swept_box_hit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // running nearest hit of the current query
    logic        near_valid;
    logic [16:0] near_frac;
    logic [15:0] near_id;
    hit_t        hits_pending[$];
    int          fails = 0;
    int          results_seen = 0;
    int          queries = 0;
    bit          idle_on = 1'b1;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    function automatic longint slab_quotient(input longint num, input longint den);
        longint an, ad, q;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        q = (an <<< nsbh_pkg::FRAC_BITS) / ad;
        if (q > (64'sd4 <<< nsbh_pkg::FRAC_BITS))
            q = 64'sd4 <<< nsbh_pkg::FRAC_BITS;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic bit clip_slab(input longint org, input longint mv, input longint lo,
                                     input longint hi, inout longint t0, inout longint t1);
        longint a, b;
        if (mv == 0)
            return org >= lo && org <= hi;
        a = slab_quotient(lo - org, mv);
        b = slab_quotient(hi - org, mv);
        if ((a < b ? a : b) > t0)
            t0 = a < b ? a : b;
        if ((a < b ? b : a) < t1)
            t1 = a < b ? b : a;
        return t0 <= t1;
    endfunction

    function automatic longint scale_down(input longint mv, input longint f);
        longint p;
        p = mv * f;
        if (p >= 0)
            return p >>> nsbh_pkg::FRAC_BITS;
        return -((-p + ONE - 1) >>> nsbh_pkg::FRAC_BITS);
    endfunction

    task automatic predict_object();
        longint sx, sy, dx, dy, t0, t1;
        bit hit;
        hit_t h;
        sx = longint'(start_x);
        sy = longint'(start_y);
        dx = longint'(end_x) - sx;
        dy = longint'(end_y) - sy;
        if (blocks)
        begin
            t0 = 0;
            t1 = ONE;
            hit = clip_slab(sx, dx, longint'(box_x), longint'(box_x) + longint'(box_w),
                            t0, t1);
            if (hit)
                hit = clip_slab(sy, dy, longint'(box_y), longint'(box_y) + longint'(box_h),
                                t0, t1);
            if (hit && t1 >= 0 && t0 <= ONE)
            begin
                if (t0 < 0)
                    t0 = 0;
                if (!near_valid || t0 < near_frac || (t0 == near_frac && object_id < near_id))
                begin
                    near_valid = 1'b1;
                    near_frac = t0[16:0];
                    near_id = object_id;
                end
            end
        end
        if (last_object)
        begin
            h = '{1'b0, 16'h0, 17'h0, 32'h0, 32'h0};
            if (near_valid)
            begin
                h.found = 1'b1;
                h.id = near_id;
                h.frac = near_frac;
                h.px = 32'(sx + scale_down(dx, longint'(near_frac)));
                h.py = 32'(sy + scale_down(dy, longint'(near_frac)));
            end
            hits_pending.push_back(h);
            near_valid = 1'b0;
            near_frac = '0;
            near_id = '0;
            queries++;
        end
    endtask

    task automatic send_object(input logic [31:0] sx, sy, ex, ey, bx, by, bw, bh,
                               input logic blk, input logic [31:0] id, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
        box_x <= bx; box_y <= by; box_w <= bw[30:0]; box_h <= bh[30:0];
        blocks <= blk; object_id <= id[15:0]; last_object <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_object();
        // leave valid up: the next call drives a new request or drops it
        @(negedge clk);
    endtask

    // receiver stall in bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        hit_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (hits_pending.size() == 0)
                report_mismatch("unexpected result", longint'(hit_found), 64'sd0);
            else
            begin
                w = hits_pending.pop_front();
                if (hit_found !== w.found)
                    report_mismatch("hit_found", longint'(hit_found), longint'(w.found));
                if (hit_id !== w.id)
                    report_mismatch("hit_id", longint'(hit_id), longint'(w.id));
                if (hit_fraction !== w.frac)
                    report_mismatch("hit_fraction", longint'(hit_fraction), longint'(w.frac));
                if (hit_x !== w.px)
                    report_mismatch("hit_x", longint'(hit_x), longint'(w.px));
                if (hit_y !== w.py)
                    report_mismatch("hit_y", longint'(hit_y), longint'(w.py));
            end
        end
    end

    function automatic logic [31:0] near_coord(input logic [31:0] c);
        return c + 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
    endfunction

    task automatic test_directed();
        // hit at the middle, then a tie with a smaller id
        send_object(0, 0, 32'h000a0000, 0, 32'h00040000, 32'hffff0000, 32'h20000, 32'h20000,
                    1'b1, 7, 1'b0);
        send_object(0, 0, 32'h000a0000, 0, 32'h00040000, 32'hffff0000, 32'h10000, 32'h10000,
                    1'b1, 3, 1'b1);
        // no hit, last not blocking
        send_object(0, 0, 32'h10000, 32'h10000, 32'h00050000, 32'h50000, 32'h10000, 32'h10000,
                    1'b1, 1, 1'b0);
        send_object(0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000, 1'b0, 2, 1'b1);
        // start inside, zero movement on both axes
        send_object(32'h8000, 32'h8000, 32'h8000, 32'h8000, 0, 0, 32'h10000, 32'h10000,
                    1'b1, 32'hffff, 1'b1);
        // touching a corner, and zero movement on the edge
        send_object(0, 0, 32'h20000, 32'h20000, 32'h10000, 32'h10000, 0, 0, 1'b1, 5, 1'b1);
        send_object(32'h10000, 0, 32'h10000, 32'h40000, 0, 32'h10000, 32'h10000, 32'h10000,
                    1'b1, 0, 1'b1);
        // extremes: full range segment and huge box, saturating quotients
        send_object(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                    32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1, 32'h8000, 1'b0);
        send_object(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 32'h0001, 1'b1);
        send_object(0, 0, 1, 1, 32'h7fff0000, 32'h7fff0000, 1, 1, 1'b1, 9, 1'b1);
        // segment differs between items
        send_object(0, 0, 32'h40000, 0, 32'h10000, 32'hffff0000, 32'h10000, 32'h20000,
                    1'b1, 4, 1'b0);
        send_object(32'h30000, 32'h30000, 32'h30000, 32'hfffd0000, 0, 0, 0, 0, 1'b1, 8, 1'b1);
    endtask

    task automatic test_random_queries(input int n_items);
        int sent;
        int len;
        logic [31:0] sx, sy, ex, ey;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 6);
            sx = $urandom_range(0, 3) == 0 ? $urandom() : near_coord(0);
            sy = $urandom_range(0, 3) == 0 ? $urandom() : near_coord(0);
            ex = $urandom_range(0, 5) == 0 ? sx : near_coord(sx);
            ey = $urandom_range(0, 5) == 0 ? sy : near_coord(sy);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_object($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom(), $urandom(), 1'($urandom()), $urandom(),
                                k == len - 1);
                else
                    send_object(sx, sy, ex, ey, near_coord(sx), near_coord(sy),
                                $urandom_range(0, 3 << 16), $urandom_range(0, 3 << 16),
                                $urandom_range(0, 4) != 0, $urandom_range(0, 7),
                                k == len - 1);
                sent++;
            end
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (hits_pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        near_valid = 1'b0;
        near_frac = '0;
        near_id = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_queries(700);
        // hold off until the block has drained
        wait_results_drained();
        test_random_queries(700);
        idle_on = 1'b0;
        test_random_queries(350);
        wait_results_drained();
        repeat (200) @(negedge clk);
        $display("ran %0d queries, %0d results checked, %0d mismatches",
                 queries, results_seen, fails);
        if (fails == 0 && hits_pending.size() == 0)
            $display("nearest_swept_box_hit_test: PASS");
        else
            $display("nearest_swept_box_hit_test: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("nearest_swept_box_hit_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/nsbh_pkg.sv
hdl/nsbh_div.sv
hdl/nsbh_dp.sv
hdl/nsbh_ctrl.sv
hdl/nearest_swept_box_hit.sv
tb/nearest_swept_box_hit_test.sv
